@@ sv/cssm_pkg.sv @@
// Shared types and codes for the community set masked match unit.
`timescale 1ns / 1ps

package cssm_pkg;

  // Operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_MATCH  = 2'd2;

  // Mask bit positions
  localparam int SEL_ASN = 0;
  localparam int SEL_VAL = 1;

  // Request payload
  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] comm_asn;
    logic [15:0] comm_value;
    logic [1:0]  match_mask;
  } req_t;

  // Result payload
  typedef struct packed {
    logic        hit;
    logic [6:0]  entry_total;
    logic [31:0] set_digest;
    logic        dropped_full;
  } rsp_t;

  // One stored community
  typedef struct packed {
    logic [15:0] asn;
    logic [15:0] val;
  } ent_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic        vld;
    logic        hit;
    logic [15:0] asn;
    logic [15:0] val;
    logic [1:0]  mask;
  } tok_t;

endpackage

@@ sv/community_set_masked_match_unit.sv @@
// Top level of the community set masked match unit: control, summary, digest and cell chain.
//
//   channel   signals            direction  handshake
//   request   start, req, busy   in         taken when start && !busy
//   result    done, rsp          out        one-cycle strobe, always taken
//
// Clear, insert and unused codes give their result in the cycle after the request.
// A match that the OR summary rejects, or on an empty set, also answers in the cycle after the request.
// Any other match walks the cell chain, one cell a cycle, with busy high meanwhile; the result
// is registered once the token leaves the last cell. Reset empties the set at once.
// The receiver cannot stall; each result shows for exactly one cycle.
`timescale 1ns / 1ps

module community_set_masked_match_unit
  import cssm_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output rsp_t rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic { S_IDLE, S_SEARCH } state_t;

  state_t      state;
  logic [CW-1:0] count;
  logic [31:0] or_summary;
  logic [31:0] digest;

  logic          accept;
  logic          full;
  logic          store;
  logic          reject;
  logic          launch;
  logic [CW-1:0] count_next;
  logic [31:0]   digest_ins;
  logic [31:0]   count_ext;
  logic [31:0]   or_summary_next;
  logic [31:0]   digest_next;

  ent_t ent_new;
  ent_t ent_q [DEPTH];
  tok_t tok   [DEPTH+1];

  assign accept = start && !busy;
  assign full   = (count >= CW'(DEPTH));
  assign store  = accept && (req.operation == OP_INSERT) && !full;

  // Summary test: a selected half with bits outside the OR cannot match
  assign reject = (req.match_mask[SEL_ASN] && ((or_summary[15:0] & req.comm_asn) != req.comm_asn))
               || (req.match_mask[SEL_VAL] &&
                   ((or_summary[31:16] & req.comm_value) != req.comm_value));
  assign launch = accept && (req.operation == OP_MATCH) && !reject && (count != '0);

  // h * 31 + (asn | value), wrapping
  assign digest_ins = (digest << 5) - digest + {16'd0, req.comm_asn | req.comm_value};

  // Count after this request
  always_comb begin
    count_next = count;
    if (accept) begin
      case (req.operation)
        OP_CLEAR:  count_next = '0;
        OP_INSERT: if (!full) count_next = count + CW'(1);
        default:   count_next = count;
      endcase
    end
  end

  assign count_ext = 32'(count_next);

  // Summary and digest after this request
  always_comb begin
    or_summary_next = or_summary;
    digest_next     = digest;
    case (req.operation)
      OP_CLEAR: begin
        or_summary_next = '0;
        digest_next     = '0;
      end
      OP_INSERT: begin
        if (!full) begin
          or_summary_next = or_summary | {req.comm_value, req.comm_asn};
          digest_next     = digest_ins;
        end
      end
      default: begin
        or_summary_next = or_summary;
        digest_next     = digest;
      end
    endcase
  end

  // Head of the chain
  assign ent_new.asn = req.comm_asn;
  assign ent_new.val = req.comm_value;

  assign tok[0].vld  = launch;
  assign tok[0].hit  = 1'b0;
  assign tok[0].asn  = req.comm_asn;
  assign tok[0].val  = req.comm_value;
  assign tok[0].mask = req.match_mask;

  // Cell chain; cells below the count hold live entries
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cssm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift_en (store),
      .ent_in   ((i == 0) ? ent_new : ent_q[(i == 0) ? 0 : i - 1]),
      .ent_out  (ent_q[i]),
      .active   (count > CW'(i)),
      .tok_in   (tok[i]),
      .tok_out  (tok[i+1])
    );
  end

  // Control, set state and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      busy       <= 1'b0;
      done       <= 1'b0;
      count      <= '0;
      or_summary <= '0;
      digest     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          // a launched search answers later from the chain
          done <= accept && !launch;
          if (accept) begin
            count            <= count_next;
            or_summary       <= or_summary_next;
            digest           <= digest_next;
            rsp.entry_total  <= count_ext[6:0];
            rsp.hit          <= 1'b0;
            rsp.dropped_full <= (req.operation == OP_INSERT) && full;
            rsp.set_digest   <= digest_next;
            if (launch) begin
              state <= S_SEARCH;
              busy  <= 1'b1;
            end
          end
        end
        S_SEARCH: begin
          done <= tok[DEPTH].vld;
          if (tok[DEPTH].vld) begin
            rsp.hit <= tok[DEPTH].hit;
            busy    <= 1'b0;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
          done  <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_not_busy : assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while search still running");
  a_tok_in_search : assert property (@(posedge clk) disable iff (rst)
    tok[DEPTH].vld |-> (state == S_SEARCH))
    else $error("search token left the chain outside a search");
  a_launch_busy : assert property (@(posedge clk) disable iff (rst) launch |=> busy)
    else $error("launched search did not raise busy");
  a_count_bound : assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("entry count above depth");
  a_count_hold : assert property (@(posedge clk) disable iff (rst) busy |=> $stable(count))
    else $error("entry count changed during a search");
`endif

endmodule

@@ sv/cssm_cell.sv @@
// One cell of the community chain: holds an entry and checks a passing search token.
`timescale 1ns / 1ps

module cssm_cell
  import cssm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic shift_en,
  input  ent_t ent_in,
  output ent_t ent_out,
  input  logic active,
  input  tok_t tok_in,
  output tok_t tok_out
);

  ent_t ent;
  logic agree;

  assign ent_out = ent;

  // Entry shifts toward the tail on every stored insert
  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent <= ent_in;
    end
  end

  // Masked compare against the held entry
  assign agree = (!tok_in.mask[SEL_ASN] || (tok_in.asn == ent.asn)) &&
                 (!tok_in.mask[SEL_VAL] || (tok_in.val == ent.val));

  // Token moves one cell per cycle, collecting the hit
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
    tok_out.hit  <= tok_in.hit | (active & agree);
    tok_out.asn  <= tok_in.asn;
    tok_out.val  <= tok_in.val;
    tok_out.mask <= tok_in.mask;
  end

endmodule

@@ dv/community_set_masked_match_unit_tb.sv @@
// Self-checking testbench for the community set masked match unit.
`timescale 1ns / 1ps

module community_set_masked_match_unit_tb;
  import cssm_pkg::*;

  localparam int DEPTH = 64;
  localparam int ITEM_TARGET = 1700;
  localparam int BURST_ITEMS = 200;
  // Longest quiet stretch of a correct run is one full chain walk plus a sender gap
  localparam int WATCHDOG_LIMIT = 20 * (DEPTH + 2);

  // Unused operation code, and the mask settings
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [1:0] MASK_ANY  = 2'd0;
  localparam logic [1:0] MASK_ASN  = 2'd1;
  localparam logic [1:0] MASK_VAL  = 2'd2;
  localparam logic [1:0] MASK_BOTH = 2'd3;

  logic clk;
  logic rst;
  logic start;
  req_t req;
  logic busy;
  logic done;
  rsp_t rsp;

  community_set_masked_match_unit #(.DEPTH(DEPTH)) u_dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .req  (req),
    .busy (busy),
    .done (done),
    .rsp  (rsp)
  );

  // Mirror of the community set
  logic [15:0] held_asn [DEPTH];
  logic [15:0] held_val [DEPTH];
  int          held_count = 0;
  logic [31:0] held_or_summary = '0;
  logic [31:0] held_digest = '0;

  rsp_t awaited_rsp [$];
  rsp_t want;
  int   error_count = 0;
  int   requests_sent = 0;
  int   stall_cycles = 0;
  int   gap_percent = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Masked search: OR summary rejects first, then scan the held entries
  function automatic logic search_held(req_t r);
    logic [15:0] sum_asn;
    logic [15:0] sum_val;
    sum_asn = held_or_summary[15:0];
    sum_val = held_or_summary[31:16];
    if (r.match_mask[SEL_ASN] && ((sum_asn & r.comm_asn) != r.comm_asn)) return 1'b0;
    if (r.match_mask[SEL_VAL] && ((sum_val & r.comm_value) != r.comm_value)) return 1'b0;
    for (int i = 0; i < held_count; i++) begin
      if (r.match_mask[SEL_ASN] && held_asn[i] != r.comm_asn) continue;
      if (r.match_mask[SEL_VAL] && held_val[i] != r.comm_value) continue;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one request to the mirror and return the response it should give
  function automatic rsp_t predict_set_response(req_t r);
    rsp_t o;
    o = '0;
    case (r.operation)
      OP_CLEAR: begin
        held_count = 0;
        held_or_summary = '0;
        held_digest = '0;
      end
      OP_INSERT: begin
        if (held_count >= DEPTH) begin
          o.dropped_full = 1'b1;
        end else begin
          held_asn[held_count] = r.comm_asn;
          held_val[held_count] = r.comm_value;
          held_count++;
          held_or_summary = held_or_summary | {r.comm_value, r.comm_asn};
          held_digest = held_digest * 32'd31 + {16'h0000, r.comm_asn | r.comm_value};
        end
      end
      OP_MATCH: o.hit = search_held(r);
      default: ;
    endcase
    o.entry_total = 7'(held_count);
    o.set_digest = held_digest;
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    error_count++;
    if (error_count <= 100)
      $display("%0t: %s: expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
  endtask

  // Response checker and request predictor, both on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (awaited_rsp.size() == 0) begin
          report_mismatch("response with no request pending", 32'd0, 32'(rsp));
        end else begin
          want = awaited_rsp.pop_front();
          if (rsp.hit !== want.hit) report_mismatch("hit", 32'(want.hit), 32'(rsp.hit));
          if (rsp.entry_total !== want.entry_total)
            report_mismatch("entry_total", 32'(want.entry_total), 32'(rsp.entry_total));
          if (rsp.set_digest !== want.set_digest)
            report_mismatch("set_digest", want.set_digest, rsp.set_digest);
          if (rsp.dropped_full !== want.dropped_full)
            report_mismatch("dropped_full", 32'(want.dropped_full), 32'(rsp.dropped_full));
        end
      end
      if (start && !busy) awaited_rsp.push_back(predict_set_response(req));
    end
  end

  // Watchdog: cycles with neither a request taken nor a response
  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic req_t mk_req(logic [1:0] op, logic [15:0] asn, logic [15:0] val,
                                  logic [1:0] mask);
    req_t r;
    r.operation = op;
    r.comm_asn = asn;
    r.comm_value = val;
    r.match_mask = mask;
    return r;
  endfunction

  // Half-community values: extremes, a small pool for collisions, or anything
  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 7));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  // Queries mostly aim at held entries, exact, with one half swapped or one bit off
  function automatic req_t build_query();
    req_t q;
    int idx;
    int kind;
    q = mk_req(OP_MATCH, pick_half(), pick_half(), 2'($urandom_range(0, 3)));
    kind = $urandom_range(0, 9);
    if (held_count > 0 && kind < 8) begin
      idx = $urandom_range(0, held_count - 1);
      q.comm_asn = held_asn[idx];
      q.comm_value = held_val[idx];
      if (kind == 4 || kind == 5) begin
        if ($urandom_range(0, 1)) q.comm_asn = pick_half();
        else q.comm_value = pick_half();
      end else if (kind >= 6) begin
        if ($urandom_range(0, 1)) q.comm_asn = q.comm_asn ^ (16'h0001 << $urandom_range(0, 15));
        else q.comm_value = q.comm_value ^ (16'h0001 << $urandom_range(0, 15));
      end
    end
    return q;
  endfunction

  function automatic req_t build_noise();
    return mk_req(2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)),
                  16'($urandom_range(0, 16'hFFFF)), 2'($urandom_range(0, 3)));
  endfunction

  // Drive one request at the falling edge and hold it until taken
  task automatic send_request(req_t r);
    if ($urandom_range(0, 99) < gap_percent) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start <= 1'b1;
    req <= r;
    do @(posedge clk); while (busy);
    if (r.operation != OP_UNUSED) requests_sent++;
  endtask

  task automatic send_insert();
    send_request(mk_req(OP_INSERT, pick_half(), pick_half(), 2'($urandom_range(0, 3))));
  endtask

  // Extremes, every operation, empty mask, unused code, summary rejection, digest growth
  task automatic test_directed_cases();
    send_request(mk_req(OP_MATCH, 16'h0000, 16'h0000, MASK_ANY));
    send_request(mk_req(OP_MATCH, 16'hFFFF, 16'hFFFF, MASK_BOTH));
    send_request(mk_req(OP_UNUSED, 16'hFFFF, 16'hFFFF, MASK_BOTH));
    send_request(mk_req(OP_INSERT, 16'h0000, 16'h0000, MASK_ANY));
    send_request(mk_req(OP_MATCH, 16'hFFFF, 16'hFFFF, MASK_ANY));
    send_request(mk_req(OP_MATCH, 16'h0000, 16'h0000, MASK_BOTH));
    send_request(mk_req(OP_INSERT, 16'hFFFF, 16'hFFFF, MASK_BOTH));
    send_request(mk_req(OP_INSERT, 16'hFFFF, 16'h0000, MASK_ANY));
    send_request(mk_req(OP_INSERT, 16'h0000, 16'hFFFF, MASK_ANY));
    send_request(mk_req(OP_MATCH, 16'hFFFF, 16'h1234, MASK_ASN));
    send_request(mk_req(OP_MATCH, 16'h4321, 16'hFFFF, MASK_VAL));
    send_request(mk_req(OP_MATCH, 16'hFFFF, 16'h0000, MASK_BOTH));
    send_request(mk_req(OP_UNUSED, 16'h0000, 16'h0000, MASK_ANY));
    send_request(mk_req(OP_CLEAR, 16'hFFFF, 16'hFFFF, MASK_BOTH));
    send_request(mk_req(OP_INSERT, 16'h0001, 16'h0002, MASK_BOTH));
    // summary rejects these without a walk
    send_request(mk_req(OP_MATCH, 16'h0004, 16'h0002, MASK_ASN));
    send_request(mk_req(OP_MATCH, 16'h0001, 16'h0001, MASK_VAL));
    send_request(mk_req(OP_MATCH, 16'h0001, 16'h0003, MASK_BOTH));
    send_request(mk_req(OP_INSERT, 16'h0003, 16'h0000, MASK_ANY));
    // both pass the summary; the first misses on the walk, the second hits
    send_request(mk_req(OP_MATCH, 16'h0002, 16'h0002, MASK_BOTH));
    send_request(mk_req(OP_MATCH, 16'h0003, 16'hBEEF, MASK_ASN));
    // digest grows into its upper bits without wrapping
    repeat (4) send_request(mk_req(OP_INSERT, 16'hFFFF, 16'hFFFF, MASK_ANY));
  endtask

  // Fill to capacity, overflow, then search both ends and an emptied set
  task automatic test_full_set_overflow();
    gap_percent = 20;
    send_request(mk_req(OP_CLEAR, pick_half(), pick_half(), 2'($urandom_range(0, 3))));
    repeat (DEPTH) send_insert();
    repeat (3) send_insert();
    send_request(mk_req(OP_MATCH, held_asn[0], held_val[0], MASK_BOTH));
    send_request(mk_req(OP_MATCH, held_asn[DEPTH-1], held_val[DEPTH-1], MASK_BOTH));
    repeat (4) send_request(build_query());
    send_request(mk_req(OP_UNUSED, pick_half(), pick_half(), MASK_BOTH));
    send_request(mk_req(OP_CLEAR, pick_half(), pick_half(), MASK_ANY));
    send_request(mk_req(OP_MATCH, pick_half(), pick_half(), MASK_ANY));
  endtask

  // One session: usually a clear, a fill, then a run of queries with stray items
  task automatic run_session();
    int fill;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) fill = $urandom_range(0, 10);
    else if (roll < 95) fill = $urandom_range(11, 40);
    else fill = $urandom_range(DEPTH - 4, DEPTH + 6);
    if ($urandom_range(0, 9) != 0)
      send_request(mk_req(OP_CLEAR, pick_half(), pick_half(), 2'($urandom_range(0, 3))));
    repeat (fill) begin
      if ($urandom_range(0, 19) == 0) send_request(build_noise());
      else send_insert();
    end
    repeat ($urandom_range(1, 12)) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) send_request(build_noise());
      else if (roll == 1) send_insert();
      else send_request(build_query());
    end
  endtask

  task automatic test_random_sessions();
    int pick;
    while (requests_sent < ITEM_TARGET - BURST_ITEMS) begin
      pick = $urandom_range(0, 2);
      gap_percent = (pick == 0) ? 0 : (pick == 1) ? 15 : 50;
      run_session();
    end
  endtask

  // Closing stretch with the request side never idle
  task automatic test_back_to_back();
    gap_percent = 0;
    while (requests_sent < ITEM_TARGET) run_session();
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_full_set_overflow();
    test_random_sessions();
    test_back_to_back();

    @(negedge clk);
    start <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
    if (awaited_rsp.size() != 0)
      report_mismatch("responses still missing", 32'd0, awaited_rsp.size());

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
